// ----- rtl/core/hm_pkg.sv -----
// Package for the heightmap triangle interpolator.
// Shared constants, register indexes and inter-module structs; no dependencies.
`timescale 1ns / 1ps

package hm_pkg;

  localparam int unsigned MAP_SIDE_DEF = 256;

  // Configuration register indexes
  localparam logic [1:0] REG_HEIGHT_SCALE = 2'd0;
  localparam logic [1:0] REG_CELLS_ACROSS = 2'd1;
  localparam logic [1:0] REG_CELLS_DOWN   = 2'd2;

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [15:0] SCALE_RST = 16'd205;
  localparam logic [7:0]  CELLS_RST = 8'd255;

  typedef struct packed {
    logic [15:0] height_scale;
    logic [7:0]  cells_across;
    logic [7:0]  cells_down;
  } hm_cfg_t;

  // Front end to memory stage
  typedef struct packed {
    logic       query;
    logic       wr_ok;
    logic [7:0] wr_val;
    logic       oor;
    logic [7:0] fx;
    logic [7:0] fz;
    logic [2:0] rd_ok;
  } hm_fe_t;

  // Memory stage to arithmetic back end
  typedef struct packed {
    logic       oor;
    logic [7:0] fx;
    logic [7:0] fz;
    logic [2:0] rd_ok;
  } hm_mix_t;

endpackage

// ----- rtl/core/hm_if.sv -----
// Valid/ready channel interfaces for the heightmap interpolator.
// Query/write input channel and height result channel; no dependencies.
`timescale 1ns / 1ps

interface hm_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [15:0] sample_index;
  logic [7:0]  sample_value;
  logic [15:0] pos_x;
  logic [15:0] pos_z;

  modport source (output valid, func, sample_index, sample_value, pos_x, pos_z,
                  input ready);
  modport sink   (input valid, func, sample_index, sample_value, pos_x, pos_z,
                  output ready);
endinterface

interface hm_out_if;
  logic        valid;
  logic        ready;
  logic [19:0] height_out;
  logic        out_of_range;

  modport source (output valid, height_out, out_of_range, input ready);
  modport sink   (input valid, height_out, out_of_range, output ready);
endinterface

// ----- rtl/core/heightmap_triangle_interpolate.sv -----
// Heightmap triangle interpolator: a query gives a result once it has passed
// through every stage; write beats store a sample and give no result.
// One beat per cycle sustained while out_ch.ready is high, set by the seven-stage pipeline and three
// copies of the sample store, one per corner read port, written together.
// Reset (synchronous, rst_n low) clears pipeline valids and loads register
// defaults; the sample store is not cleared and holds garbage until written.
`timescale 1ns / 1ps

module heightmap_triangle_interpolate #(
  parameter int unsigned MAP_SIDE = hm_pkg::MAP_SIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  hm_in_if.sink       in_ch,
  hm_out_if.source    out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW = $clog2(DEPTH);

  hm_pkg::hm_cfg_t cfg_r;
  hm_pkg::hm_fe_t  fe;
  hm_pkg::hm_mix_t mix_r, mix_nxt;

  logic                fe_v;
  logic [AW-1:0]       wr_addr;
  logic [2:0][AW-1:0]  rd_addr;
  logic [2:0][7:0]     samples;
  logic                v4_r;
  logic                en4, en5;
  logic                ram_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.height_scale <= hm_pkg::SCALE_RST;
      cfg_r.cells_across <= hm_pkg::CELLS_RST;
      cfg_r.cells_down   <= hm_pkg::CELLS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hm_pkg::REG_HEIGHT_SCALE: cfg_r.height_scale <= cfg_data;
        hm_pkg::REG_CELLS_ACROSS: cfg_r.cells_across <= cfg_data[7:0];
        hm_pkg::REG_CELLS_DOWN:   cfg_r.cells_down   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  hm_front #(.MAP_SIDE(MAP_SIDE)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cfg      (cfg_r),
    .dn_ready (en4),
    .fe_v     (fe_v),
    .fe       (fe),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr)
  );

  // Stage 4: store access. Reads and writes are issued from the same stage,
  // so they hit the store in beat order.
  assign en4    = !v4_r || en5;
  assign ram_we = fe_v && !fe.query && fe.wr_ok && en4;

  for (genvar k = 0; k < 3; k++) begin : g_store
    hm_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clk   (clk),
      .we    (ram_we),
      .waddr (wr_addr),
      .wdata (fe.wr_val),
      .re    (en4),
      .raddr (rd_addr[k]),
      .rdata (samples[k])
    );
  end

  always_comb begin
    mix_nxt.oor   = fe.oor;
    mix_nxt.fx    = fe.fx;
    mix_nxt.fz    = fe.fz;
    mix_nxt.rd_ok = fe.rd_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= fe_v && fe.query;   // write beats end here
    end
  end

  always_ff @(posedge clk) begin
    if (en4) mix_r <= mix_nxt;
  end

  hm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .mix_v        (v4_r),
    .mix          (mix_r),
    .samples      (samples),
    .height_scale (cfg_r.height_scale),
    .up_ready     (en5),
    .out_ch       (out_ch)
  );

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.out_of_range |-> out_ch.height_out == 20'd0)
    else $error("out-of-range result with nonzero height");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    fe_v && !fe.query && en4 |=> !v4_r)
    else $error("write beat entered the result path");

  a_samples_held: assert property (@(posedge clk) disable iff (!rst_n)
    !en4 |=> $stable(samples))
    else $error("read data changed during a stall");

  a_stage4_held: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !en4 |=> v4_r && $stable(mix_r))
    else $error("stalled query lost at store stage");

endmodule

// ----- rtl/core/hm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/hm_front.sv -----
// Front end, stages 1-3: position shift, range check, triangle pick,
// row base products and corner addresses. Depends on hm_pkg and hm_if.
`timescale 1ns / 1ps

module hm_front #(
  parameter int unsigned MAP_SIDE = hm_pkg::MAP_SIDE_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  hm_in_if.sink                                      in_ch,
  input  hm_pkg::hm_cfg_t                            cfg,
  input  logic                                       dn_ready,
  output logic                                       fe_v,
  output hm_pkg::hm_fe_t                             fe,
  output logic [$clog2(MAP_SIDE*MAP_SIDE)-1:0]       wr_addr,
  output logic [2:0][$clog2(MAP_SIDE*MAP_SIDE)-1:0]  rd_addr
);

  localparam int unsigned DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW = $clog2(DEPTH);
  localparam int SW = (AW + 1 > 18) ? AW + 1 : 18;

  typedef struct packed {
    logic          query;
    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_val;
    logic          oor;
    logic [7:0]    ix;
    logic [7:0]    iz;
    logic [7:0]    fx;
    logic [7:0]    fz;
    logic          up;
  } s1_t;

  typedef struct packed {
    logic          query;
    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_val;
    logic          oor;
    logic [7:0]    ix;
    logic [16:0]   base_lo;
    logic [16:0]   base_hi;
    logic [7:0]    fx;
    logic [7:0]    fz;
    logic          up;
  } s2_t;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt, s3_r;

  logic [16:0] x_sh, z_sh;
  logic [7:0]  fx0, fz0;
  logic        up0;
  logic [SW-1:0] idx_ext;
  logic [8:0]  stride;
  logic [8:0]  col_a, col_b;
  logic [16:0] rb_a, rb_b;
  logic [2:0][SW-1:0] addr;

  assign en3 = !v3_r || dn_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  // Stage 1: shift by half the cell count (cells * 128 in Q8.8)
  always_comb begin
    x_sh = {in_ch.pos_x[15], in_ch.pos_x} + {2'b00, cfg.cells_across, 7'd0};
    z_sh = {in_ch.pos_z[15], in_ch.pos_z} + {2'b00, cfg.cells_down, 7'd0};
    fx0  = x_sh[7:0];
    fz0  = z_sh[7:0];
    up0  = ({1'b0, fx0} + {1'b0, fz0}) > 9'd256;
    idx_ext = SW'(in_ch.sample_index);

    s1_nxt.query   = in_ch.func == hm_pkg::FUNC_QUERY;
    s1_nxt.wr_ok   = idx_ext < SW'(DEPTH);
    s1_nxt.wr_addr = idx_ext[AW-1:0];
    s1_nxt.wr_val  = in_ch.sample_value;
    // far edges count as outside; zero cells makes everything outside
    s1_nxt.oor     = x_sh[16] || z_sh[16] ||
                     (x_sh[15:0] >= {cfg.cells_across, 8'd0}) ||
                     (z_sh[15:0] >= {cfg.cells_down, 8'd0});
    s1_nxt.ix      = x_sh[15:8];
    s1_nxt.iz      = z_sh[15:8];
    s1_nxt.fx      = up0 ? 8'(9'd256 - {1'b0, fx0}) : fx0;
    s1_nxt.fz      = up0 ? 8'(9'd256 - {1'b0, fz0}) : fz0;
    s1_nxt.up      = up0;
  end

  // Stage 2: row base addresses for rows iz and iz+1
  always_comb begin
    stride = {1'b0, cfg.cells_across} + 9'd1;
    s2_nxt.query   = s1_r.query;
    s2_nxt.wr_ok   = s1_r.wr_ok;
    s2_nxt.wr_addr = s1_r.wr_addr;
    s2_nxt.wr_val  = s1_r.wr_val;
    s2_nxt.oor     = s1_r.oor;
    s2_nxt.ix      = s1_r.ix;
    s2_nxt.base_lo = 17'(s1_r.iz * stride);
    s2_nxt.base_hi = 17'(({1'b0, s1_r.iz} + 9'd1) * stride);
    s2_nxt.fx      = s1_r.fx;
    s2_nxt.fz      = s1_r.fz;
    s2_nxt.up      = s1_r.up;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1_r <= s1_nxt;
    if (en2) s2_r <= s2_nxt;
    if (en3) s3_r <= s2_r;
  end

  // Stage 3: corners. Lower: (iz,ix) (iz+1,ix) (iz,ix+1);
  // upper: (iz+1,ix+1) (iz,ix+1) (iz+1,ix).
  always_comb begin
    col_a = {1'b0, s3_r.ix} + {8'd0, s3_r.up};
    col_b = {1'b0, s3_r.ix} + {8'd0, !s3_r.up};
    rb_a  = s3_r.up ? s3_r.base_hi : s3_r.base_lo;
    rb_b  = s3_r.up ? s3_r.base_lo : s3_r.base_hi;
    addr[0] = SW'(rb_a) + SW'(col_a);
    addr[1] = SW'(rb_b) + SW'(col_a);
    addr[2] = SW'(rb_a) + SW'(col_b);
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_addr[k]  = addr[k][AW-1:0];
      fe.rd_ok[k] = addr[k] < SW'(DEPTH);
    end
    fe.query  = s3_r.query;
    fe.wr_ok  = s3_r.wr_ok;
    fe.wr_val = s3_r.wr_val;
    fe.oor    = s3_r.oor;
    fe.fx     = s3_r.fx;
    fe.fz     = s3_r.fz;
  end

  assign wr_addr = s3_r.wr_addr;
  assign fe_v    = v3_r;

endmodule

// ----- rtl/core/hm_back.sv -----
// Back end, stages 5-7: barycentric products, sum, gain multiply and
// result register. Depends on hm_pkg and hm_if.
`timescale 1ns / 1ps

module hm_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            mix_v,
  input  hm_pkg::hm_mix_t mix,
  input  logic [2:0][7:0] samples,
  input  logic [15:0]     height_scale,
  output logic            up_ready,
  hm_out_if.source        out_ch
);

  typedef struct packed {
    logic              oor;
    logic [7:0]        t0;
    logic signed [16:0] p1;
    logic signed [16:0] p2;
  } s5_t;

  typedef struct packed {
    logic        oor;
    logic [15:0] h;
  } s6_t;

  typedef struct packed {
    logic        oor;
    logic [19:0] height;
  } s7_t;

  logic v5_r, v6_r, v7_r;
  logic en5, en6, en7;
  s5_t  s5_r, s5_nxt;
  s6_t  s6_r, s6_nxt;
  s7_t  s7_r, s7_nxt;

  logic [2:0][7:0]    t;
  logic signed [8:0]  d1, d2;
  logic signed [17:0] p1_w, p2_w;
  logic signed [17:0] hsum;
  logic [31:0]        prod;

  assign en7 = !v7_r || out_ch.ready;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign up_ready = en5;

  always_comb begin
    // corners beyond the store read as zero
    for (int k = 0; k < 3; k++) begin
      t[k] = mix.rd_ok[k] ? samples[k] : 8'd0;
    end
    d1   = $signed({1'b0, t[1]}) - $signed({1'b0, t[0]});
    d2   = $signed({1'b0, t[2]}) - $signed({1'b0, t[0]});
    p1_w = $signed({1'b0, mix.fz}) * d1;
    p2_w = $signed({1'b0, mix.fx}) * d2;
    s5_nxt.oor = mix.oor;
    s5_nxt.t0  = t[0];
    s5_nxt.p1  = p1_w[16:0];
    s5_nxt.p2  = p2_w[16:0];
  end

  always_comb begin
    hsum = $signed({2'b00, s5_r.t0, 8'd0}) + $signed({s5_r.p1[16], s5_r.p1}) +
           $signed({s5_r.p2[16], s5_r.p2});
    s6_nxt.oor = s5_r.oor;
    s6_nxt.h   = hsum[17] ? 16'd0 : hsum[15:0];
  end

  always_comb begin
    prod = s6_r.h * height_scale;
    s7_nxt.oor    = s6_r.oor;
    s7_nxt.height = s6_r.oor ? 20'd0 : prod[31:12];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en5) v5_r <= mix_v;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) s5_r <= s5_nxt;
    if (en6) s6_r <= s6_nxt;
    if (en7) s7_r <= s7_nxt;
  end

  assign out_ch.valid        = v7_r;
  assign out_ch.height_out   = s7_r.height;
  assign out_ch.out_of_range = s7_r.oor;

endmodule
